@@ hw/rtl/lds_pkg.sv @@
// Shared types for the linear Diophantine solver: controller states,
// datapath command and status structs. No dependencies.
package lds_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_EUC_RUN,
    ST_EUC_UPD,
    ST_C_RUN,
    ST_C_FIN,
    ST_B_INIT,
    ST_B_RUN,
    ST_B_FIN,
    ST_A_INIT,
    ST_A_RUN,
    ST_A_FIN,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ZERO_RES,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EUC_UPD,
    OP_C_FIN,
    OP_B_FIN,
    OP_A_FIN,
    OP_PUBLISH
  } dp_op_t;

  // Operand selection for a divider pass
  typedef enum logic [1:0] {
    SEL_EUC,  // r0 / r1, multiplies s1 and t1
    SEL_C,    // c / g, multiplies s0 and t0
    SEL_B,    // b / g
    SEL_NA    // (-a) / g
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic ab_zero;
    logic r1_zero;
    logic div_last;
    logic rem_zero;
  } dp_stat_t;

endpackage

@@ hw/rtl/linear_diophantine_solver_core.sv @@
// Solves a*x + b*y = c by iterative extended Euclid: one item at a time.
// An item with no solution skips the last two divisions, and one with
// a = b = 0 skips all divisions. Each division runs on the restoring
// divider, which retires one quotient bit per cycle while folding both
// Bezout products into the same pass. The result sits in an output
// register, so the next item is taken while it waits.
// Depends on lds_pkg, lds_ctl, lds_dp.
module linear_diophantine_solver_core #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] coef_a,
  input  logic [WORD_BITS-1:0] coef_b,
  input  logic [WORD_BITS-1:0] rhs_c,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 has_solution,
  output logic [WORD_BITS-1:0] divisor_gcd,
  output logic [WORD_BITS-1:0] x_base,
  output logic [WORD_BITS-1:0] x_step,
  output logic [WORD_BITS-1:0] y_base,
  output logic [WORD_BITS-1:0] y_step
);

  lds_pkg::dp_cmd_t  cmd;
  lds_pkg::dp_stat_t stat;

  lds_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lds_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .coef_a       (coef_a),
    .coef_b       (coef_b),
    .rhs_c        (rhs_c),
    .has_solution (has_solution),
    .divisor_gcd  (divisor_gcd),
    .x_base       (x_base),
    .x_step       (x_step),
    .y_base       (y_base),
    .y_step       (y_step)
  );

endmodule

@@ hw/rtl/lds_dp.sv @@
// Datapath: Euclid remainder/Bezout registers, one-bit-per-cycle restoring
// divider with Horner multiply-accumulate, result and output registers. Uses lds_pkg.
module lds_dp #(
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  lds_pkg::dp_cmd_t      cmd,
  output lds_pkg::dp_stat_t     stat,
  input  logic [WORD_BITS-1:0]  coef_a,
  input  logic [WORD_BITS-1:0]  coef_b,
  input  logic [WORD_BITS-1:0]  rhs_c,
  output logic                  has_solution,
  output logic [WORD_BITS-1:0]  divisor_gcd,
  output logic [WORD_BITS-1:0]  x_base,
  output logic [WORD_BITS-1:0]  x_step,
  output logic [WORD_BITS-1:0]  y_base,
  output logic [WORD_BITS-1:0]  y_step
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_INIT = CW'(W);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  // Euclid state
  logic [W-1:0] a_r, b_r, c_r;
  logic [W-1:0] r0, r1, s0, s1, t0, t1;

  // divider / multiplier state
  logic [W-1:0]  dvd, dvs, rem, quo, acc_s, acc_t, m_s, m_t;
  logic          q_neg, r_neg;
  logic [CW-1:0] cnt;

  // results waiting for the output register
  logic         res_has;
  logic [W-1:0] res_gcd, res_xb, res_xs, res_yb, res_ys;

  logic [W-1:0] sel_num, sel_den, sel_ms, sel_mt, neg_a;
  logic [W:0]   trial;
  logic         qbit;
  logic [W-1:0] rem_step, acc_s_step, acc_t_step;
  logic [W-1:0] quo_s, rem_s, ns, nt, xb_fix, yb_fix;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? W'(~v + 1'b1) : v;
  endfunction

  assign neg_a = W'(~a_r + 1'b1);

  always_comb begin
    case (cmd.sel)
      lds_pkg::SEL_EUC: begin
        sel_num = r0;   sel_den = r1; sel_ms = s1; sel_mt = t1;
      end
      lds_pkg::SEL_C: begin
        sel_num = c_r;  sel_den = r0; sel_ms = s0; sel_mt = t0;
      end
      lds_pkg::SEL_B: begin
        sel_num = b_r;  sel_den = r0; sel_ms = '0; sel_mt = '0;
      end
      default: begin
        sel_num = neg_a; sel_den = r0; sel_ms = '0; sel_mt = '0;
      end
    endcase
  end

  // restoring step on magnitudes; quotient bits feed the Horner products
  assign trial      = {rem, dvd[W-1]} - {1'b0, dvs};
  assign qbit       = ~trial[W];
  assign rem_step   = qbit ? trial[W-1:0] : {rem[W-2:0], dvd[W-1]};
  assign acc_s_step = {acc_s[W-2:0], 1'b0} + (qbit ? m_s : '0);
  assign acc_t_step = {acc_t[W-2:0], 1'b0} + (qbit ? m_t : '0);

  // sign fix-up, truncating semantics
  assign quo_s  = q_neg ? W'(~quo + 1'b1) : quo;
  assign rem_s  = r_neg ? W'(~rem + 1'b1) : rem;
  assign ns     = q_neg ? W'(s0 + acc_s) : W'(s0 - acc_s);
  assign nt     = q_neg ? W'(t0 + acc_t) : W'(t0 - acc_t);
  assign xb_fix = q_neg ? W'(~acc_s + 1'b1) : acc_s;
  assign yb_fix = q_neg ? W'(~acc_t + 1'b1) : acc_t;

  assign stat.ab_zero  = (a_r == '0) && (b_r == '0);
  assign stat.r1_zero  = (r1 == '0);
  assign stat.div_last = (cnt == CNT_ONE);
  assign stat.rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    case (cmd.op)
      lds_pkg::OP_LOAD: begin
        a_r <= coef_a;
        b_r <= coef_b;
        c_r <= rhs_c;
        r0  <= coef_a;
        r1  <= coef_b;
        s0  <= W'(1);
        s1  <= '0;
        t0  <= '0;
        t1  <= W'(1);
      end
      lds_pkg::OP_ZERO_RES: begin
        res_has <= (c_r == '0);
        res_gcd <= '0;
        res_xb  <= '0;
        res_xs  <= '0;
        res_yb  <= '0;
        res_ys  <= '0;
      end
      lds_pkg::OP_DIV_INIT: begin
        dvd   <= mag(sel_num);
        dvs   <= mag(sel_den);
        rem   <= '0;
        quo   <= '0;
        acc_s <= '0;
        acc_t <= '0;
        m_s   <= sel_ms;
        m_t   <= sel_mt;
        q_neg <= sel_num[W-1] ^ sel_den[W-1];
        r_neg <= sel_num[W-1];
        cnt   <= CNT_INIT;
      end
      lds_pkg::OP_DIV_STEP: begin
        dvd   <= {dvd[W-2:0], 1'b0};
        rem   <= rem_step;
        quo   <= {quo[W-2:0], qbit};
        acc_s <= acc_s_step;
        acc_t <= acc_t_step;
        cnt   <= cnt - CNT_ONE;
      end
      lds_pkg::OP_EUC_UPD: begin
        r0 <= r1;
        r1 <= rem_s;
        s0 <= s1;
        s1 <= ns;
        t0 <= t1;
        t1 <= nt;
      end
      lds_pkg::OP_C_FIN: begin
        res_has <= stat.rem_zero;
        res_gcd <= r0;
        res_xb  <= stat.rem_zero ? xb_fix : '0;
        res_yb  <= stat.rem_zero ? yb_fix : '0;
        res_xs  <= '0;
        res_ys  <= '0;
      end
      lds_pkg::OP_B_FIN: res_xs <= quo_s;
      lds_pkg::OP_A_FIN: res_ys <= quo_s;
      lds_pkg::OP_PUBLISH: begin
        has_solution <= res_has;
        divisor_gcd  <= res_gcd;
        x_base       <= res_xb;
        x_step       <= res_xs;
        y_base       <= res_yb;
        y_step       <= res_ys;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/lds_ctl.sv @@
// Controller: sequences Euclid iterations and the three final divisions,
// owns the handshakes and the output valid flag. Uses lds_pkg.
module lds_ctl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lds_pkg::dp_stat_t  stat,
  output lds_pkg::dp_cmd_t   cmd
);

  lds_pkg::ctl_state_t state, state_next;
  logic out_valid_next;
  logic slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lds_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.op         = lds_pkg::OP_NONE;
    cmd.sel        = lds_pkg::SEL_EUC;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      lds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = lds_pkg::OP_LOAD;
          state_next = lds_pkg::ST_TEST;
        end
      end
      lds_pkg::ST_TEST: begin
        if (stat.ab_zero) begin
          cmd.op     = lds_pkg::OP_ZERO_RES;
          state_next = lds_pkg::ST_DONE;
        end else if (stat.r1_zero) begin
          cmd.op     = lds_pkg::OP_DIV_INIT;
          cmd.sel    = lds_pkg::SEL_C;
          state_next = lds_pkg::ST_C_RUN;
        end else begin
          cmd.op     = lds_pkg::OP_DIV_INIT;
          cmd.sel    = lds_pkg::SEL_EUC;
          state_next = lds_pkg::ST_EUC_RUN;
        end
      end
      lds_pkg::ST_EUC_RUN: begin
        cmd.op = lds_pkg::OP_DIV_STEP;
        if (stat.div_last) state_next = lds_pkg::ST_EUC_UPD;
      end
      lds_pkg::ST_EUC_UPD: begin
        cmd.op     = lds_pkg::OP_EUC_UPD;
        state_next = lds_pkg::ST_TEST;
      end
      lds_pkg::ST_C_RUN: begin
        cmd.op = lds_pkg::OP_DIV_STEP;
        if (stat.div_last) state_next = lds_pkg::ST_C_FIN;
      end
      lds_pkg::ST_C_FIN: begin
        cmd.op     = lds_pkg::OP_C_FIN;
        state_next = stat.rem_zero ? lds_pkg::ST_B_INIT : lds_pkg::ST_DONE;
      end
      lds_pkg::ST_B_INIT: begin
        cmd.op     = lds_pkg::OP_DIV_INIT;
        cmd.sel    = lds_pkg::SEL_B;
        state_next = lds_pkg::ST_B_RUN;
      end
      lds_pkg::ST_B_RUN: begin
        cmd.op = lds_pkg::OP_DIV_STEP;
        if (stat.div_last) state_next = lds_pkg::ST_B_FIN;
      end
      lds_pkg::ST_B_FIN: begin
        cmd.op     = lds_pkg::OP_B_FIN;
        state_next = lds_pkg::ST_A_INIT;
      end
      lds_pkg::ST_A_INIT: begin
        cmd.op     = lds_pkg::OP_DIV_INIT;
        cmd.sel    = lds_pkg::SEL_NA;
        state_next = lds_pkg::ST_A_RUN;
      end
      lds_pkg::ST_A_RUN: begin
        cmd.op = lds_pkg::OP_DIV_STEP;
        if (stat.div_last) state_next = lds_pkg::ST_A_FIN;
      end
      lds_pkg::ST_A_FIN: begin
        cmd.op     = lds_pkg::OP_A_FIN;
        state_next = lds_pkg::ST_DONE;
      end
      lds_pkg::ST_DONE: begin
        // wait until the output register is free
        if (slot_free) begin
          cmd.op         = lds_pkg::OP_PUBLISH;
          out_valid_next = 1'b1;
          state_next     = lds_pkg::ST_IDLE;
        end
      end
      default: state_next = lds_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/lds_checker.sv @@
// Port-level checks for linear_diophantine_solver_core, bound to the top level.
// No package dependencies.
module lds_checker #(
  parameter int WORD_BITS = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 has_solution,
  input logic [WORD_BITS-1:0] divisor_gcd,
  input logic [WORD_BITS-1:0] x_base,
  input logic [WORD_BITS-1:0] x_step,
  input logic [WORD_BITS-1:0] y_base,
  input logic [WORD_BITS-1:0] y_step
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the beat was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(divisor_gcd) && $stable(x_base) &&
      $stable(x_step) && $stable(y_base) && $stable(y_step) && $stable(has_solution))
    else $error("result payload changed while stalled");

  // one item at a time: accepting an input closes the input side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_no_solution_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_solution |->
      x_base == '0 && x_step == '0 && y_base == '0 && y_step == '0)
    else $error("nonzero solution fields without a solution");

  a_zero_gcd: assert property (@(posedge clk) disable iff (rst)
    out_valid && divisor_gcd == '0 |->
      x_base == '0 && x_step == '0 && y_base == '0 && y_step == '0)
    else $error("zero gcd with nonzero solution fields");

endmodule

bind linear_diophantine_solver_core lds_checker #(
  .WORD_BITS (WORD_BITS)
) u_lds_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .has_solution (has_solution),
  .divisor_gcd  (divisor_gcd),
  .x_base       (x_base),
  .x_step       (x_step),
  .y_base       (y_base),
  .y_step       (y_step)
);
